// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define EMAG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger in one cycle implies consequence in the next.
`define EMAG_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/emag_pkg.sv =====
package emag_pkg;

  // Configuration register file
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Frame geometry limits
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 2048;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int HGT_W      = ROW_W + 1;
  localparam int RST_DIM    = 2048;

  // Per-pixel position flags handed from the sequencer to the datapath
  typedef struct packed {
    logic emit;   // window is centered on an interior pixel
    logic last;   // final pixel of the frame
  } pos_flags_t;

endpackage

// ===== rtl/emag_ctrl.sv =====
module emag_ctrl
  import emag_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int COL_W     = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  step,
  output logic [COL_W-1:0]      cur_col,
  output logic [ROW_W-1:0]      cur_row,
  output pos_flags_t            flags
);

`include "assert_macros.svh"

  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int WCMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int W_RST  = (MAX_WIDTH < RST_DIM) ? MAX_WIDTH : RST_DIM;

  logic [CNT_W-1:0] w_r, w_nxt;
  logic [HGT_W-1:0] h_r, h_nxt;
  logic [COL_W-1:0] col_count_r, col_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;

  logic [WCMP_W-1:0] wr_ext;
  logic              col_wrap;
  logic [HGT_W-1:0]  row_t;
  logic [CNT_W-1:0]  col_inc;
  logic [HGT_W-1:0]  row_inc;
  logic              line_end;
  logic              frame_wrap;

  // Registers hold the clamped geometry
  assign wr_ext = WCMP_W'(cfg_wdata);

  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH: begin
          if (wr_ext < WCMP_W'(MIN_DIM)) begin
            w_nxt = CNT_W'(MIN_DIM);
          end else if (wr_ext > WCMP_W'(MAX_WIDTH)) begin
            w_nxt = CNT_W'(MAX_WIDTH);
          end else begin
            w_nxt = CNT_W'(wr_ext);
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_wdata < CFG_W'(MIN_DIM)) begin
            h_nxt = HGT_W'(MIN_DIM);
          end else if (cfg_wdata > CFG_W'(MAX_HEIGHT)) begin
            h_nxt = HGT_W'(MAX_HEIGHT);
          end else begin
            h_nxt = HGT_W'(cfg_wdata);
          end
        end
        default: begin
          w_nxt = w_r;
        end
      endcase
    end
  end

  // Position of the arriving pixel; wraps cover a geometry shrink mid-frame
  always_comb begin
    col_wrap   = CNT_W'(col_count_r) >= w_r;
    cur_col    = col_wrap ? '0 : col_count_r;
    row_t      = col_wrap ? HGT_W'(row_count_r) + HGT_W'(1) : HGT_W'(row_count_r);
    cur_row    = (row_t >= h_r) ? '0 : row_t[ROW_W-1:0];
    col_inc    = CNT_W'(cur_col) + CNT_W'(1);
    row_inc    = HGT_W'(cur_row) + HGT_W'(1);
    line_end   = col_inc >= w_r;
    frame_wrap = row_inc >= h_r;
    flags.emit = (cur_col >= COL_W'(2)) && (cur_row >= ROW_W'(2));
    flags.last = line_end && frame_wrap;
  end

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (step) begin
      if (line_end) begin
        col_count_nxt = '0;
        row_count_nxt = frame_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_count_nxt = col_inc[COL_W-1:0];
        row_count_nxt = cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= CNT_W'(W_RST);
      h_r         <= HGT_W'(RST_DIM);
      col_count_r <= '0;
      row_count_r <= '0;
    end else begin
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  `EMAG_ASSERT_NEXT(a_col_in_line, clk, rst_n, step, CNT_W'(col_count_r) < w_r, "column counter past line width")
  `EMAG_ASSERT_NEXT(a_row_in_frame, clk, rst_n, step, HGT_W'(row_count_r) < h_r, "row counter past frame height")

endmodule

// ===== rtl/emag_line_buf.sv =====
module emag_line_buf
  import emag_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 8,
  parameter int COL_W      = 11
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [COL_W-1:0]      rd_addr,
  input  logic                  wr_en,
  input  logic [COL_W-1:0]      wr_addr,
  input  logic [PIXEL_BITS-1:0] wr_top,
  input  logic [PIXEL_BITS-1:0] wr_mid,
  output logic [PIXEL_BITS-1:0] rd_top,
  output logic [PIXEL_BITS-1:0] rd_mid
);

  // Two lines back and one line back, one entry per column
  logic [PIXEL_BITS-1:0] top_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mid_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      top_mem[wr_addr] <= wr_top;
      mid_mem[wr_addr] <= wr_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_top <= top_mem[rd_addr];
      rd_mid <= mid_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/emag_window.sv =====
module emag_window
  import emag_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic [PIXEL_BITS-1:0] pix,
  input  logic [PIXEL_BITS-1:0] top,
  input  logic [PIXEL_BITS-1:0] mid,
  output logic [PIXEL_BITS-1:0] mag
);

  localparam int DW = PIXEL_BITS + 3;

  // Column two back (w0..w2) and one back (w3..w5), top to bottom
  logic [PIXEL_BITS-1:0] win_r [6];

  logic signed [DW-1:0] dv, dh;
  logic [DW-1:0]        abs_v, abs_h, sum;

  function automatic logic signed [DW-1:0] sx(input logic [PIXEL_BITS-1:0] p);
    return $signed({3'b000, p});
  endfunction

  always_comb begin
    dv    = (sx(win_r[2]) - sx(win_r[0])) + (sx(win_r[5]) - sx(win_r[3]))
          + (sx(pix) - sx(top));
    dh    = (sx(top) - sx(win_r[0])) + (sx(mid) - sx(win_r[1]))
          + (sx(pix) - sx(win_r[2]));
    abs_v = dv[DW-1] ? DW'(-dv) : DW'(dv);
    abs_h = dh[DW-1] ? DW'(-dh) : DW'(dh);
    sum   = abs_v + abs_h;
    mag   = (sum > {3'b000, {PIXEL_BITS{1'b1}}}) ? {PIXEL_BITS{1'b1}}
                                                   : sum[PIXEL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= pix;
    end
  end

endmodule

// ===== rtl/edge_magnitude_3x3_unit.sv =====
// 3x3 Prewitt edge magnitude over a raster pixel stream.
// Input channel (in_*): one grayscale pixel word per accepted handshake
// (in_valid high, in_stall low), frames in raster order, line by line.
// Output channel (out_*): one word per interior pixel with the saturated
// magnitude |vertical diff sum| + |horizontal diff sum|, the center
// column/row, and out_frame_end on the last interior word of the frame.
// Border pixels produce no output word.
// Config (cfg_*): line_width (index 0) and frame_height (index 1), clamped
// to 3..MAX_WIDTH and 3..2048; write only while the pipe is empty.
// Throughput: one pixel per clock while out_stall does not hold the pipe.
// An accepted pixel passes stage 1 (with the line buffer read), then the
// result reg, which drives out_*.
// The line buffer is read at accept and written with the shifted lines when
// the word leaves stage 1; neighboring pixels never share a column.
// Stall: out_stall holds the result reg; if the input stage is empty, one more
// pixel is still taken into it, after which in_stall rises until the result drains.
// Reset (rst_n low, sync): counters, window and valids clear; geometry
// returns to min(MAX_WIDTH, 2048) x 2048. Line buffer contents are not cleared
// and are never used for the first two rows of a frame.
module edge_magnitude_3x3_unit
  import emag_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config write port
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PIXEL_BITS-1:0]         in_pixel,
  // edge output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [PIXEL_BITS-1:0]         out_edge_value,
  output logic [$clog2(MAX_WIDTH)-1:0]  out_center_col,
  output logic [ROW_W-1:0]              out_center_row,
  output logic                          out_frame_end
);

`include "assert_macros.svh"

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic in_accept;
  logic s1_fire;
  logic out_free;

  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  pos_flags_t       cur_flags;

  // Stage 1: pixel + position, line buffer read data lands alongside
  logic                  s1_valid_r, s1_valid_nxt;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [COL_W-1:0]      s1_col_r;
  logic [ROW_W-1:0]      s1_row_r;
  pos_flags_t            s1_flags_r;
  logic [PIXEL_BITS-1:0] lb_top, lb_mid;

  logic [PIXEL_BITS-1:0] mag;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic [PIXEL_BITS-1:0] out_edge_r;
  logic [COL_W-1:0]      out_col_r;
  logic [ROW_W-1:0]      out_row_r;
  logic                  out_end_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  emag_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (in_accept),
    .cur_col   (cur_col),
    .cur_row   (cur_row),
    .flags     (cur_flags)
  );

  // Read at accept, write back (shifted lines) when the word leaves stage 1
  emag_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .COL_W      (COL_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (cur_col),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_top  (lb_mid),
    .wr_mid  (s1_pix_r),
    .rd_top  (lb_top),
    .rd_mid  (lb_mid)
  );

  emag_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_fire),
    .pix      (s1_pix_r),
    .top      (lb_top),
    .mid      (lb_mid),
    .mag      (mag)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = s1_flags_r.emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r   <= in_pixel;
      s1_col_r   <= cur_col;
      s1_row_r   <= cur_row;
      s1_flags_r <= cur_flags;
    end
  end

  // Border words retire through stage 1 without touching the result reg
  always_ff @(posedge clk) begin
    if (s1_fire && s1_flags_r.emit) begin
      out_edge_r <= mag;
      out_col_r  <= s1_col_r - COL_W'(1);
      out_row_r  <= s1_row_r - ROW_W'(1);
      out_end_r  <= s1_flags_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_value = out_edge_r;
  assign out_center_col = out_col_r;
  assign out_center_row = out_row_r;
  assign out_frame_end  = out_end_r;

  `EMAG_ASSERT(a_stall_only_when_full, clk, rst_n,
               !in_stall || (s1_valid_r && out_valid_r), "input stalled with room in the pipe")
  `EMAG_ASSERT_NEXT(a_emit_lands, clk, rst_n, s1_fire && s1_flags_r.emit,
                    out_valid_r, "interior word lost at result register")
  `EMAG_ASSERT(a_center_interior, clk, rst_n,
               !out_valid_r || (out_col_r != '0 && out_row_r != '0), "border pixel reported")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the 3x3 Prewitt edge magnitude unit.
// A small in-bench predictor mirrors the line store, window and position
// counters; every accepted pixel word may queue one expected edge word, and
// every accepted output word is compared field by field with the oldest one.
module tb;
  import emag_pkg::*;

  localparam int LINE_MAX    = 2048;
  localparam int COL_BITS    = $clog2(LINE_MAX);
  localparam int LIMIT       = 1_000_000;  // cycles before the run is declared hung
  localparam int DRAIN_PAUSE = 8;          // pipe is two deep; generous margin
  localparam int HOLD_CYCLES = 400;        // long output hold for the fill-up test

  // One expected output word.
  typedef struct packed {
    bit [7:0]          mag;
    bit [COL_BITS-1:0] col;
    bit [ROW_W-1:0]    row;
    bit                last;
  } edge_word_t;

  // Predictor plus expected-word store.
  class edge_checker;
    bit [7:0]    line_mem [2*LINE_MAX];  // [col] = line above, [LINE_MAX+col] = two above
    bit [7:0]    win [6];                // older column in 0..2, newer in 3..5
    bit [11:0]   width_reg;
    bit [11:0]   height_reg;
    int          col_cnt;
    int          row_cnt;
    int          cols_seen;              // columns written at least once since reset
    int          cols_twice;             // columns written at least twice since reset
    int          pixels;
    int          words;
    int          frames;
    int          errors;
    edge_word_t  edges_due[$];

    function new();
      width_reg  = 12'(RST_DIM);
      height_reg = 12'(RST_DIM);
    endfunction

    function int clamp_dim(int v, int hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    function int eff_width();
      return clamp_dim(int'(width_reg), LINE_MAX);
    endfunction

    function int eff_height();
      return clamp_dim(int'(height_reg), MAX_HEIGHT);
    endfunction

    function bit at_frame_start();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [11:0] val);
      if (idx == REG_LINE_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function void take_pixel(bit [7:0] pix);
      int w, h, col, row, dv, dh, mag;
      bit [7:0] top, mid;
      edge_word_t e;
      w = eff_width();
      h = eff_height();
      // geometry may have shrunk under the counters
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      col = col_cnt;
      row = row_cnt;
      top = line_mem[LINE_MAX + col];
      mid = line_mem[col];
      line_mem[LINE_MAX + col] = mid;
      line_mem[col] = pix;
      // lines always start at column 0, so both sets are prefixes
      if (col + 1 > cols_seen) cols_seen = col + 1;
      else if (col + 1 > cols_twice) cols_twice = col + 1;
      pixels++;
      if (col >= 2 && row >= 2) begin
        dv = int'(win[2]) - int'(win[0]) + int'(win[5]) - int'(win[3])
           + int'(pix) - int'(top);
        dh = int'(top) - int'(win[0]) + int'(mid) - int'(win[1])
           + int'(pix) - int'(win[2]);
        mag = (dv < 0 ? -dv : dv) + (dh < 0 ? -dh : dh);
        if (mag > 255) mag = 255;
        e.mag  = mag[7:0];
        e.col  = COL_BITS'(col - 1);
        e.row  = ROW_W'(row - 1);
        e.last = (col == w - 1) && (row == h - 1);
        edges_due = {edges_due, e};
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = pix;
      col_cnt = col + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = row + 1;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    function void check_word(logic [7:0] mag, logic [COL_BITS-1:0] col,
                             logic [ROW_W-1:0] row, logic last);
      edge_word_t e;
      if (edges_due.size() == 0) begin
        $error("unexpected edge word: edge_value %0d center_col %0d center_row %0d",
               mag, col, row);
        errors++;
        return;
      end
      e = edges_due.pop_front();
      words++;
      if (e.last) frames++;
      if (mag !== e.mag) begin
        $error("edge_value: expected %0d, got %0d", e.mag, mag);
        errors++;
      end
      if (col !== e.col) begin
        $error("center_col: expected %0d, got %0d", e.col, col);
        errors++;
      end
      if (row !== e.row) begin
        $error("center_row: expected %0d, got %0d", e.row, row);
        errors++;
      end
      if (last !== e.last) begin
        $error("frame_end: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_LINE_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata  = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_pixel   = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [7:0]           out_edge_value;
  logic [COL_BITS-1:0]  out_center_col;
  logic [ROW_W-1:0]     out_center_row;
  logic                 out_frame_end;

  edge_magnitude_3x3_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_edge_value (out_edge_value),
    .out_center_col (out_center_col),
    .out_center_row (out_center_row),
    .out_frame_end  (out_frame_end)
  );

  edge_checker sb = new();

  int   src_idle_pct  = 0;   // chance per cycle that the sender holds back
  int   snk_stall_pct = 0;   // chance per cycle that the receiver stalls
  logic hold_active   = 1'b0;
  int   cycles        = 0;
  event stall_burst;

  // Hand-picked opening pixels: a start at reset geometry, a row pair after a
  // mid-frame shrink, then a saturating top-to-bottom step and a flat frame.
  bit [7:0] directed_px [27] = '{
    255, 0, 255,
    0, 128, 255, 255, 128, 0,
    255, 255, 255, 128, 128, 128, 0, 0, 0,
    77, 77, 77, 77, 77, 77, 77, 77, 77
  };

  initial begin
    forever #2 clk = ~clk;
  end

  // Hang guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("edge_magnitude_3x3_unit: mismatch");
      $finish;
    end
  end

  // Receiver: check each accepted word (values seen here are the pre-edge
  // ones), then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      sb.check_word(out_edge_value, out_center_col, out_center_row, out_frame_end);
    if (hold_active) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  // Long output hold, timed here so the sender keeps pushing meanwhile.
  initial begin
    forever begin
      @(stall_burst);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both
  function automatic void set_idle(int mode);
    case (mode)
      0: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      1: begin
        src_idle_pct  = 52;
        snk_stall_pct = 0;
      end
      2: begin
        src_idle_pct  = 0;
        snk_stall_pct = 52;
      end
      default: begin
        src_idle_pct  = 23;
        snk_stall_pct = 23;
      end
    endcase
  endfunction

  // Mostly uniform, with a heavy share of black and white to hit saturation.
  function automatic bit [7:0] rand_pixel();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // Offer one pixel word and wait for it to be taken.
  task automatic send_pixel(input bit [7:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (in_stall);
    sb.take_pixel(pix);
  endtask

  // Stop sending and wait until every expected word is back and the pipe
  // has had time to swallow trailing border pixels.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.edges_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Write both geometry registers while idle. Growing the line mid-frame is
  // capped to columns written at least twice, so both store slots that a
  // result reads hold real pixels.
  task automatic set_geometry(input int w_raw, input int h_raw);
    if (!sb.at_frame_start() && sb.clamp_dim(w_raw, LINE_MAX) > sb.eff_width() &&
        sb.clamp_dim(w_raw, LINE_MAX) > sb.cols_twice)
      w_raw = sb.cols_twice;
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_WIDTH;
    cfg_wdata <= CFG_W'(w_raw);
    @(posedge clk);
    sb.set_reg(REG_LINE_WIDTH, 12'(w_raw));
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= CFG_W'(h_raw);
    @(posedge clk);
    sb.set_reg(REG_FRAME_HEIGHT, 12'(h_raw));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int w_raw, h_raw, n, w, h, seg;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    set_idle(0);
    // three pixels of row 0 at the 2048x2048 reset geometry
    for (int i = 0; i < 3; i++) send_pixel(directed_px[i]);
    drain();
    // width below range (clamps to 3) lands mid-line: next pixel opens row 1;
    // height with the top bit set clamps to 2048
    set_geometry(2, 4095);
    for (int i = 3; i < 9; i++) send_pixel(directed_px[i]);
    drain();
    // height 0 clamps to 3; row counter is already past it, so a new frame
    // starts: minimal 3x3 frames, one saturated word then one zero word
    set_geometry(3, 0);
    for (int i = 9; i < 27; i++) send_pixel(directed_px[i]);
    drain();

    // --- geometry extremes: a stretch of a full-width line, then a shrink
    // to the narrowest line under the tallest frame ---
    set_idle(3);
    set_geometry(LINE_MAX, 3);
    repeat (64) send_pixel(rand_pixel());
    drain();
    set_geometry(3, MAX_HEIGHT);
    repeat (3 * 40) send_pixel(rand_pixel());
    drain();

    // --- fill-up: receiver holds off while the sender keeps offering ---
    set_idle(0);
    set_geometry(8, 6);
    -> stall_burst;
    repeat (96) send_pixel(rand_pixel());
    drain();

    // --- random segments, each its own geometry and idling mode ---
    seg = 0;
    while (sb.pixels < 750) begin
      set_idle(seg % 4);
      case ($urandom_range(9))
        0:       w_raw = $urandom_range(0, 2);
        1:       w_raw = $urandom_range(13, 40);
        default: w_raw = $urandom_range(3, 12);
      endcase
      case ($urandom_range(9))
        0:       h_raw = $urandom_range(0, 2);
        1:       h_raw = $urandom_range(13, 4095);
        default: h_raw = $urandom_range(3, 8);
      endcase
      set_geometry(w_raw, h_raw);
      w = sb.eff_width();
      h = sb.eff_height();
      // mostly whole frames; sometimes a partial run so the next write
      // lands mid-frame
      if (h <= 12 && $urandom_range(9) > 2) n = w * h * $urandom_range(1, 2);
      else n = $urandom_range(1, 3 * w);
      if (n > 780 - sb.pixels) n = 780 - sb.pixels;
      repeat (n) send_pixel(rand_pixel());
      seg++;
      drain();
    end

    $display("run covered %0d pixels over %0d geometry settings, %0d edge words checked",
             sb.pixels, seg + 6, sb.words);
    $display("including %0d frame ends, clamped and mid-frame geometry writes, long output hold",
             sb.frames);
    if (sb.errors == 0) begin
      $display("edge_magnitude_3x3_unit: match");
    end else begin
      $display("edge_magnitude_3x3_unit: mismatch");
    end
    $finish;
  end

endmodule
